FILE: rtl/core/assert_macros.svh
// Assertion macros used by sorted_id_table_remove to check its own behavior.
// Each expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SITR_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define SITR_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/sitr_pkg.sv
package sitr_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int ID_W            = 32;
	localparam int STATUS_W        = 2;
	localparam int ENTRIES_W       = 9;
	localparam int S_TDATA_W       = 32;
	localparam int M_TDATA_W       = 16;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic                load;
		logic                append;
		logic                init_search;
		logic                rd_mid;
		logic                step_lo;
		logic                step_hi;
		logic                shift_init;
		logic                shift_step;
		logic                count_dec;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic op_remove;
		logic full;
		logic empty;
		logic range_empty;
		logic key_gt;
		logic key_lt;
		logic shift_done;
		logic res_busy;
	} sts_t;

endpackage

FILE: rtl/core/sitr_datapath.sv
module sitr_datapath #(
	parameter int TABLE_DEPTH = sitr_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sitr_pkg::cmd_t                 cmd,
	output sitr_pkg::sts_t                 sts,
	input  logic                           in_op,
	input  logic [sitr_pkg::ID_W-1:0]      in_id,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [sitr_pkg::STATUS_W-1:0]  res_status,
	output logic [sitr_pkg::ENTRIES_W-1:0] res_entries
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [sitr_pkg::ID_W-1:0] id_store [TABLE_DEPTH];

	logic                              op_q;
	logic [sitr_pkg::ID_W-1:0]         key_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     lo_q;
	logic [CW-1:0]                     hip1_q;
	logic [CW-1:0]                     mid_q;
	logic [CW-1:0]                     rd_ptr_q;
	logic [AW-1:0]                     wr_ptr_q;
	logic                              pend_q;
	logic [sitr_pkg::ID_W-1:0]         rd_data_q;
	logic                              res_valid_q;
	logic [sitr_pkg::STATUS_W-1:0]     res_status_q;
	logic [sitr_pkg::ENTRIES_W-1:0]    res_entries_q;

	logic [CW:0]                       mid_sum;
	logic [CW-1:0]                     mid_w;
	logic                              more;
	logic                              rd_en;
	logic [AW-1:0]                     rd_addr;
	logic                              wr_en;
	logic [AW-1:0]                     wr_addr;
	logic [sitr_pkg::ID_W-1:0]         wr_data;
	logic [CW+sitr_pkg::ENTRIES_W-1:0] count_ext;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hip1_q} - (CW+1)'(1);
	assign mid_w     = mid_sum[CW:1];
	assign more      = rd_ptr_q < count_q;
	assign count_ext = {{sitr_pkg::ENTRIES_W{1'b0}}, count_q};

	assign rd_en   = cmd.rd_mid | (cmd.shift_step & more);
	assign rd_addr = cmd.rd_mid ? mid_w[AW-1:0] : rd_ptr_q[AW-1:0];
	assign wr_en   = cmd.append | (cmd.shift_step & pend_q);
	assign wr_addr = cmd.append ? count_q[AW-1:0] : wr_ptr_q;
	assign wr_data = cmd.append ? key_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_store[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= id_store[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			key_q <= in_id;
		end
		if (cmd.init_search) begin
			lo_q   <= '0;
			hip1_q <= count_q;
		end else if (cmd.step_lo) begin
			lo_q <= mid_q + CW'(1);
		end else if (cmd.step_hi) begin
			hip1_q <= mid_q;
		end
		if (cmd.rd_mid) begin
			mid_q <= mid_w;
		end
		if (cmd.shift_init) begin
			rd_ptr_q <= mid_q + CW'(1);
			wr_ptr_q <= mid_q[AW-1:0];
		end else if (cmd.shift_step) begin
			if (more) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (pend_q) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
		end
		if (cmd.res_load) begin
			res_status_q  <= cmd.res_status;
			res_entries_q <= count_ext[sitr_pkg::ENTRIES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.shift_init) begin
				pend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				pend_q <= more;
			end
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op_remove   = (op_q == sitr_pkg::OP_REMOVE);
		sts.full        = (count_q == CW'(TABLE_DEPTH));
		sts.empty       = (count_q == '0);
		sts.range_empty = (lo_q >= hip1_q);
		sts.key_gt      = (rd_data_q < key_q);
		sts.key_lt      = (key_q < rd_data_q);
		sts.shift_done  = !more && !pend_q;
		sts.res_busy    = res_valid_q && !res_ready;
	end

	assign res_valid   = res_valid_q;
	assign res_status  = res_status_q;
	assign res_entries = res_entries_q;

endmodule

FILE: rtl/core/sitr_ctrl.sv
module sitr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sitr_pkg::sts_t sts,
	output sitr_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SRCH_RD  = 6'b000100,
		S_SRCH_CMP = 6'b001000,
		S_SHIFT    = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t                        state_q;
	state_t                        state_d;
	logic [sitr_pkg::STATUS_W-1:0] status_q;
	logic [sitr_pkg::STATUS_W-1:0] status_d;

	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		cmd            = '0;
		cmd.res_status = status_q;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!sts.op_remove) begin
					if (sts.full) begin
						status_d = sitr_pkg::ST_FULL;
					end else begin
						cmd.append = 1'b1;
						status_d   = sitr_pkg::ST_DONE;
					end
					state_d = S_RESP;
				end else begin
					cmd.init_search = 1'b1;
					state_d         = S_SRCH_RD;
				end
			end
			S_SRCH_RD: begin
				if (sts.range_empty) begin
					status_d = sitr_pkg::ST_NOT_FOUND;
					state_d  = S_RESP;
				end else begin
					cmd.rd_mid = 1'b1;
					state_d    = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				if (sts.key_gt) begin
					cmd.step_lo = 1'b1;
					state_d     = S_SRCH_RD;
				end else if (sts.key_lt) begin
					cmd.step_hi = 1'b1;
					state_d     = S_SRCH_RD;
				end else begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.shift_done) begin
					cmd.count_dec = 1'b1;
					status_d      = sitr_pkg::ST_DONE;
					state_d       = S_RESP;
				end
			end
			S_RESP: begin
				if (!sts.res_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= sitr_pkg::ST_DONE;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

FILE: rtl/core/sorted_id_table_remove.sv
// Channel  Direction  tdata                   tuser
// s_*      in         [31:0] id               [0] operation
// m_*      out        [8:0] entries, pad      [1:0] status
//
// An append passes through the dispatch and response states to a result in the output
// register. A remove runs a binary search, reading one table entry per step, and if it
// finds the id shifts the entries above it down one place; both use the single read port
// of the table memory. One transaction is in work at a time; a new one is
// accepted while a result still waits in the output register.
// Reset clears the entry count and the controller; the table memory is not cleared.
`include "assert_macros.svh"

module sorted_id_table_remove #(
	parameter int TABLE_DEPTH = sitr_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sitr_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] id
	input  logic                           s_tuser,  // [0] operation
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sitr_pkg::M_TDATA_W-1:0] m_tdata,  // [8:0] entries, zeros above
	output logic [sitr_pkg::STATUS_W-1:0]  m_tuser   // [1:0] status
);

	sitr_pkg::cmd_t                 cmd;
	sitr_pkg::sts_t                 sts;
	logic [sitr_pkg::ENTRIES_W-1:0] entries;

	sitr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sitr_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_op       (s_tuser),
		.in_id       (s_tdata[sitr_pkg::ID_W-1:0]),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_status  (m_tuser),
		.res_entries (entries)
	);

	assign m_tdata = {{(sitr_pkg::M_TDATA_W - sitr_pkg::ENTRIES_W){1'b0}}, entries};

	`SITR_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "second transaction accepted while one is in work")
	`SITR_ASSERT_NOW(a_full_status, !(cmd.res_load && cmd.res_status == sitr_pkg::ST_FULL) || sts.full, "full status reported on a table with room")
	`SITR_ASSERT_NOW(a_dec_nonempty, !cmd.count_dec || !sts.empty, "entry count decremented on an empty table")
	`SITR_ASSERT_NOW(a_res_no_overwrite, !cmd.res_load || !sts.res_busy, "result loaded over one not yet taken")

endmodule
